@@ src/irsfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsfp_pkg
// Shared types and character codes for the line sensor frame parser.
// ----------------------------------------------------------------------------
package irsfp_pkg;

  localparam int unsigned MAX_CH   = 8;
  localparam int unsigned DIG_BASE = 6;
  localparam int unsigned DIG_STEP = 5;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;

  typedef logic [MAX_CH-1:0][15:0] value_arr_t;

  // position inside one token
  typedef enum logic [3:0] {
    PH_BEFORE = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_GAP    = 4'b0100,
    PH_SECOND = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       load;
    value_arr_t values;
  } frame_t;

endpackage

@@ src/irsfp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsfp_if
// Valid/ready channels for received bytes and decoded channel results.
// ----------------------------------------------------------------------------
interface irsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface irsfp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel;
  logic [15:0] value;
  logic        last;

  modport source (output valid, output channel, output value, output last, input ready);
  modport sink   (input valid, input channel, input value, input last, output ready);
endinterface

@@ src/ir_sensor_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_sensor_frame_parser
// Parses '$'...'#' frames from a line sensor into one value per channel.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle; a '#' waits while the previous frame's
//   results are still going out (one result per cycle while res.ready is
//   high, NCHAN = min(CHANNELS, MAX_CH) results); after '#' is accepted the
//   first result passes the byte, frame hold and output registers
// reset: frame state and channel values cleared, mode back to digital
module ir_sensor_frame_parser #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned FRAME_MAX = 100
) (
  input  logic           clk,
  input  logic           rst,
  irsfp_byte_if.sink     rx,
  irsfp_result_if.source res,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data
);

  localparam int unsigned NCHAN = (CHANNELS < irsfp_pkg::MAX_CH) ? CHANNELS : irsfp_pkg::MAX_CH;
  localparam logic [2:0] LAST_IDX = 3'(NCHAN - 1);

  logic              mode;
  logic              emit_busy;
  irsfp_pkg::frame_t frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  irsfp_decoder #(
    .CHANNELS  (CHANNELS),
    .FRAME_MAX (FRAME_MAX)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .mode      (mode),
    .emit_busy (emit_busy),
    .frame     (frame)
  );

  irsfp_emitter #(
    .CHANNELS (CHANNELS)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .emit_busy (emit_busy),
    .res       (res)
  );

  // a new frame never overwrites one still being sent
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    frame.load |-> !emit_busy)
    else $error("frame loaded while emitter busy");

  // the marked result is always the final channel
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last |-> res.channel == LAST_IDX)
    else $error("last item on wrong channel");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid after reset");

endmodule

@@ src/irsfp_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsfp_decoder
// Registers each received byte and runs the frame, token and number tracking
// on it combinationally; hands the finished channel values to the emitter.
// ----------------------------------------------------------------------------
module irsfp_decoder #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned FRAME_MAX = 100
) (
  input  logic                clk,
  input  logic                rst,
  irsfp_byte_if.sink          rx,
  input  logic                mode,
  input  logic                emit_busy,
  output irsfp_pkg::frame_t   frame
);

  localparam int unsigned NCHAN = (CHANNELS < irsfp_pkg::MAX_CH) ? CHANNELS : irsfp_pkg::MAX_CH;
  localparam logic [3:0] TOK_MAX   = 4'(NCHAN + 1);
  localparam logic [7:0] POS_LIMIT = 8'(FRAME_MAX);

  logic                  byte_valid;
  logic [7:0]            byte_data;
  logic                  in_frame;
  logic [6:0]            byte_pos;
  logic [3:0]            token_index;
  irsfp_pkg::phase_t     phase;
  logic                  digits_active;
  logic                  negative;
  logic                  kind_ok;
  logic                  gap;
  irsfp_pkg::value_arr_t channel_values;

  logic                  in_frame_next;
  logic [6:0]            byte_pos_next;
  logic [3:0]            token_index_next;
  irsfp_pkg::phase_t     phase_next;
  logic                  digits_active_next;
  logic                  negative_next;
  logic                  kind_ok_next;
  logic                  gap_next;
  irsfp_pkg::value_arr_t channel_values_next;

  logic        is_digit;
  logic        is_delim;
  logic        ch_ok;
  logic [2:0]  ch_idx;
  logic [15:0] sel_val;
  logic [15:0] neg_val;
  logic [15:0] dig_val;
  logic [7:0]  pos_inc;
  logic        emit_req;
  logic        consume;

  assign is_digit = (byte_data >= irsfp_pkg::CHAR_ZERO) && (byte_data <= irsfp_pkg::CHAR_NINE);
  assign is_delim = (byte_data == irsfp_pkg::CHAR_COMMA) || (byte_data == irsfp_pkg::CHAR_SPACE);
  assign ch_ok    = (token_index >= 4'd2) && (token_index <= TOK_MAX);
  assign ch_idx   = 3'(token_index - 4'd2);
  assign sel_val  = channel_values[ch_idx];
  assign neg_val  = 16'd0 - sel_val;
  // times ten plus the digit
  assign dig_val  = (sel_val << 3) + (sel_val << 1) + {12'd0, byte_data[3:0]};
  assign pos_inc  = {1'b0, byte_pos} + 8'd1;

  always_comb begin
    in_frame_next       = in_frame;
    byte_pos_next       = byte_pos;
    token_index_next    = token_index;
    phase_next          = phase;
    digits_active_next  = digits_active;
    negative_next       = negative;
    kind_ok_next        = kind_ok;
    gap_next            = gap;
    channel_values_next = channel_values;
    emit_req            = 1'b0;

    if (!in_frame) begin
      if (byte_data == irsfp_pkg::CHAR_DOLLAR) begin
        in_frame_next       = 1'b1;
        channel_values_next = '0;
        token_index_next    = 4'd1;
        phase_next          = irsfp_pkg::PH_FIRST;
        digits_active_next  = 1'b0;
        negative_next       = 1'b0;
        kind_ok_next        = 1'b0;
        gap_next            = 1'b0;
        byte_pos_next       = 7'd1;
      end
    end else begin
      if (byte_pos == 7'd1) begin
        kind_ok_next = (byte_data == irsfp_pkg::CHAR_A);
      end
      if (!mode) begin
        for (int i = 0; i < NCHAN; i++) begin
          if (byte_pos == 7'(irsfp_pkg::DIG_BASE + irsfp_pkg::DIG_STEP * i)) begin
            channel_values_next[i] = {8'h00, byte_data};
          end
        end
      end

      if (byte_data == irsfp_pkg::CHAR_HASH) begin
        if (!gap) begin
          negative_next      = 1'b0;
          digits_active_next = 1'b0;
          if (mode && ch_ok && negative) begin
            channel_values_next[ch_idx] = neg_val;
          end
        end
        gap_next      = 1'b1;
        in_frame_next = 1'b0;
        byte_pos_next = 7'd0;
        emit_req      = !(mode && !kind_ok_next);
      end else begin
        if (is_delim) begin
          if (!gap) begin
            negative_next      = 1'b0;
            digits_active_next = 1'b0;
            if (mode && ch_ok && negative) begin
              channel_values_next[ch_idx] = neg_val;
            end
          end
          gap_next = 1'b1;
        end else if (gap) begin
          // first byte of a new token; never a digit of the second part
          gap_next           = 1'b0;
          token_index_next   = (token_index <= 4'(NCHAN)) ? token_index + 4'd1 : token_index;
          digits_active_next = 1'b0;
          negative_next      = 1'b0;
          phase_next         = (byte_data != irsfp_pkg::CHAR_COLON) ? irsfp_pkg::PH_FIRST
                                                                    : irsfp_pkg::PH_BEFORE;
        end else begin
          unique case (phase)
            irsfp_pkg::PH_BEFORE: begin
              if (byte_data != irsfp_pkg::CHAR_COLON) phase_next = irsfp_pkg::PH_FIRST;
            end
            irsfp_pkg::PH_FIRST: begin
              if (byte_data == irsfp_pkg::CHAR_COLON) phase_next = irsfp_pkg::PH_GAP;
            end
            irsfp_pkg::PH_GAP: begin
              if (byte_data != irsfp_pkg::CHAR_COLON) begin
                phase_next = irsfp_pkg::PH_SECOND;
                if (byte_data == irsfp_pkg::CHAR_PLUS || byte_data == irsfp_pkg::CHAR_MINUS) begin
                  negative_next      = (byte_data == irsfp_pkg::CHAR_MINUS);
                  digits_active_next = 1'b1;
                end else if (is_digit) begin
                  digits_active_next = 1'b1;
                  if (mode && ch_ok) channel_values_next[ch_idx] = dig_val;
                end else begin
                  digits_active_next = 1'b0;
                end
              end
            end
            irsfp_pkg::PH_SECOND: begin
              if (is_digit && digits_active) begin
                if (mode && ch_ok) channel_values_next[ch_idx] = dig_val;
              end else begin
                digits_active_next = 1'b0;
              end
            end
            default: phase_next = irsfp_pkg::PH_BEFORE;
          endcase
        end

        if (pos_inc >= POS_LIMIT) begin
          in_frame_next = 1'b0;
          byte_pos_next = 7'd0;
        end else begin
          byte_pos_next = pos_inc[6:0];
        end
      end
    end
  end

  // a frame end that produces results waits while the previous frame is still going out
  assign consume  = byte_valid && !(emit_req && emit_busy);
  assign rx.ready = !byte_valid || consume;

  always_comb begin
    frame.load = consume && emit_req;
    for (int i = 0; i < irsfp_pkg::MAX_CH; i++) begin
      frame.values[i] = mode ? channel_values_next[i]
                             : {8'h00, channel_values_next[i][7:0] - irsfp_pkg::CHAR_ZERO};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      byte_data <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      byte_pos       <= 7'd0;
      token_index    <= 4'd0;
      phase          <= irsfp_pkg::PH_BEFORE;
      digits_active  <= 1'b0;
      negative       <= 1'b0;
      kind_ok        <= 1'b0;
      gap            <= 1'b1;
      channel_values <= '0;
    end else if (consume) begin
      in_frame       <= in_frame_next;
      byte_pos       <= byte_pos_next;
      token_index    <= token_index_next;
      phase          <= phase_next;
      digits_active  <= digits_active_next;
      negative       <= negative_next;
      kind_ok        <= kind_ok_next;
      gap            <= gap_next;
      channel_values <= channel_values_next;
    end
  end

endmodule

@@ src/irsfp_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsfp_emitter
// Holds a finished frame and sends its channel values out one per cycle,
// while the result receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module irsfp_emitter #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  irsfp_pkg::frame_t frame,
  output logic              emit_busy,
  irsfp_result_if.source    res
);

  localparam int unsigned NCHAN = (CHANNELS < irsfp_pkg::MAX_CH) ? CHANNELS : irsfp_pkg::MAX_CH;
  localparam logic [2:0] LAST_IDX = 3'(NCHAN - 1);

  irsfp_pkg::value_arr_t snap;
  logic [2:0]            idx;
  logic                  busy;
  logic                  out_valid;
  logic [2:0]            out_channel;
  logic [15:0]           out_value;
  logic                  out_last;
  logic                  out_free;

  assign out_free  = !out_valid || res.ready;
  assign emit_busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (frame.load) begin
        busy <= 1'b1;
        idx  <= 3'd0;
      end else if (busy && out_free) begin
        idx <= idx + 3'd1;
        if (idx == LAST_IDX) busy <= 1'b0;
      end
      if (out_free) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.load) begin
      snap <= frame.values;
    end
    if (busy && out_free) begin
      out_channel <= idx;
      out_value   <= snap[idx];
      out_last    <= (idx == LAST_IDX);
    end
  end

  assign res.valid   = out_valid;
  assign res.channel = out_channel;
  assign res.value   = out_value;
  assign res.last    = out_last;

endmodule

@@ bench/irsfp_reading_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsfp_reading_checker
// Watches the byte and result channels of the line sensor frame parser,
// predicts the channel readings of every closed frame and compares them
// in order with what the parser emits.
// ----------------------------------------------------------------------------
module irsfp_reading_checker #(
  parameter int unsigned NUM_CH    = 8,
  parameter int unsigned FRAME_LEN = 100
) (
  input  logic    clk,
  input  logic    rst,
  irsfp_byte_if   rx,
  irsfp_result_if res,
  input  logic    cfg_wr_en,
  input  logic    cfg_wr_data,
  output int      mismatches,
  output int      readings_due,
  output int      readings_seen,
  output int      frames_closed,
  output int      frames_dropped
);

  localparam int NCH = (NUM_CH < irsfp_pkg::MAX_CH) ? NUM_CH : irsfp_pkg::MAX_CH;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] value;
    logic        last;
  } reading_t;

  reading_t          due_q[$];
  logic              mode_sh;
  logic              armed;
  logic [6:0]        pos;
  logic [3:0]        tok_cnt;
  irsfp_pkg::phase_t part;
  logic              digits_on;
  logic              neg;
  logic              kind_a;
  logic              between;
  logic [15:0]       acc [irsfp_pkg::MAX_CH];
  int                errs;
  int                seen;
  int                closed;
  int                dropped;

  initial begin
    errs    = 0;
    seen    = 0;
    closed  = 0;
    dropped = 0;
  end

  // channel fed by the token being read, -1 for the header and extra tokens
  function automatic int feed_slot();
    if (tok_cnt >= 2 && tok_cnt <= NCH + 1) return int'(tok_cnt) - 2;
    return -1;
  endfunction

  function automatic void close_token();
    int s;
    s = feed_slot();
    if (mode_sh && s >= 0 && neg) acc[s] = -acc[s];
    neg = 1'b0;
    digits_on = 1'b0;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    int s;
    s = feed_slot();
    if (mode_sh && s >= 0) acc[s] = 16'(acc[s] * 10 + (c - irsfp_pkg::CHAR_ZERO));
  endfunction

  function automatic void track_token(input logic [7:0] c);
    logic dig;
    dig = (c >= irsfp_pkg::CHAR_ZERO && c <= irsfp_pkg::CHAR_NINE);
    if (c == irsfp_pkg::CHAR_COMMA || c == irsfp_pkg::CHAR_SPACE) begin
      if (!between) close_token();
      between = 1'b1;
      return;
    end
    if (between) begin
      between = 1'b0;
      if (tok_cnt <= NCH) tok_cnt++;
      part = irsfp_pkg::PH_BEFORE;
      digits_on = 1'b0;
      neg = 1'b0;
    end
    case (part)
      irsfp_pkg::PH_BEFORE: begin
        if (c != irsfp_pkg::CHAR_COLON) part = irsfp_pkg::PH_FIRST;
      end
      irsfp_pkg::PH_FIRST: begin
        if (c == irsfp_pkg::CHAR_COLON) part = irsfp_pkg::PH_GAP;
      end
      irsfp_pkg::PH_GAP: begin
        if (c != irsfp_pkg::CHAR_COLON) begin
          part = irsfp_pkg::PH_SECOND;
          if (c == irsfp_pkg::CHAR_PLUS || c == irsfp_pkg::CHAR_MINUS) begin
            neg = (c == irsfp_pkg::CHAR_MINUS);
            digits_on = 1'b1;
          end else if (dig) begin
            add_digit(c);
            digits_on = 1'b1;
          end else begin
            digits_on = 1'b0;
          end
        end
      end
      default: begin
        if (dig && digits_on) add_digit(c);
        else digits_on = 1'b0;
      end
    endcase
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] c);
    int          here;
    logic [15:0] v;
    if (!armed) begin
      if (c != irsfp_pkg::CHAR_DOLLAR) return;
      armed = 1'b1;
      foreach (acc[i]) acc[i] = '0;
      tok_cnt = '0;
      part = irsfp_pkg::PH_BEFORE;
      digits_on = 1'b0;
      neg = 1'b0;
      kind_a = 1'b0;
      between = 1'b1;
      track_token(c);
      pos = 7'd1;
      return;
    end
    here = pos;
    if (here == 1) kind_a = (c == irsfp_pkg::CHAR_A);
    if (!mode_sh && here >= irsfp_pkg::DIG_BASE &&
        (here - irsfp_pkg::DIG_BASE) % irsfp_pkg::DIG_STEP == 0 &&
        (here - irsfp_pkg::DIG_BASE) / irsfp_pkg::DIG_STEP < NCH)
      acc[(here - irsfp_pkg::DIG_BASE) / irsfp_pkg::DIG_STEP] = {8'h00, c};
    if (c == irsfp_pkg::CHAR_HASH) begin
      if (!between) close_token();
      between = 1'b1;
      armed = 1'b0;
      pos = '0;
      // analog frames without the 'A' kind byte produce nothing
      if (mode_sh && !kind_a) return;
      for (int n = 0; n < NCH; n++) begin
        v = acc[n];
        if (!mode_sh) v = {8'h00, v[7:0] - irsfp_pkg::CHAR_ZERO};
        due_q.push_back('{channel: 3'(n), value: v, last: (n == NCH - 1)});
      end
      closed++;
      return;
    end
    track_token(c);
    if (here + 1 >= FRAME_LEN) begin
      armed = 1'b0;
      pos = '0;
      dropped++;
      return;
    end
    pos = 7'(here + 1);
  endfunction

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst) begin
      due_q.delete();
      mode_sh = 1'b0;
      armed = 1'b0;
      pos = '0;
      tok_cnt = '0;
      part = irsfp_pkg::PH_BEFORE;
      digits_on = 1'b0;
      neg = 1'b0;
      kind_a = 1'b0;
      between = 1'b1;
      foreach (acc[i]) acc[i] = '0;
    end else begin
      if (rx.valid && rx.ready) decode_rx_byte(rx.rx_byte);
      if (cfg_wr_en) mode_sh = cfg_wr_data;
      if (res.valid && res.ready) begin
        got = '{channel: res.channel, value: res.value, last: res.last};
        seen++;
        if (due_q.size() == 0) begin
          $error("unexpected reading: channel %0d value %0d last %0d",
                 got.channel, got.value, got.last);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (got.channel !== want.channel) begin
            $error("channel mismatch: expected %0d, got %0d", want.channel, got.channel);
            errs++;
          end
          if (got.value !== want.value) begin
            $error("value mismatch: expected %0d, got %0d", want.value, got.value);
            errs++;
          end
          if (got.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, got.last);
            errs++;
          end
        end
      end
    end
    mismatches     <= errs;
    readings_due   <= due_q.size();
    readings_seen  <= seen;
    frames_closed  <= closed;
    frames_dropped <= dropped;
  end

endmodule

@@ bench/ir_sensor_frame_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_sensor_frame_parser_test
// Feeds digital and analog sensor frames, idle noise, truncated and
// over-long frames into the parser under random stalls on both channels;
// a separate checker predicts every reading and reports mismatches.
// ----------------------------------------------------------------------------
module ir_sensor_frame_parser_test;

  localparam int unsigned NUM_CH      = 8;
  localparam int unsigned FRAME_LEN   = 100;
  localparam int          SETTLE      = 24;
  localparam int          RAND_BYTES  = 340;
  localparam int          CYCLE_LIMIT = 300000;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic cur_mode;
  bit   steady;
  int   mismatches;
  int   readings_due;
  int   readings_seen;
  int   frames_closed;
  int   frames_dropped;
  int   bytes_sent;
  int   cycles = 0;

  irsfp_byte_if   rx_if ();
  irsfp_result_if res_if ();

  ir_sensor_frame_parser #(
    .CHANNELS (NUM_CH),
    .FRAME_MAX(FRAME_LEN)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_if),
    .res        (res_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  irsfp_reading_checker #(
    .NUM_CH   (NUM_CH),
    .FRAME_LEN(FRAME_LEN)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx_if),
    .res           (res_if),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatches    (mismatches),
    .readings_due  (readings_due),
    .readings_seen (readings_seen),
    .frames_closed (frames_closed),
    .frames_dropped(frames_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    res_if.ready <= steady || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_rx(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 32) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_rx(s[i]);
  endtask

  // hold the sender until every predicted reading is out, then let the
  // pipeline empty in case the last bytes produce nothing
  task automatic drain_and_settle();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    int rand_start;
    int pick;
    int r;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    cur_mode      = 1'b0;
    steady        = 1'b0;
    bytes_sent    = 0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // digital: idle junk, an empty frame, '$' and a zero byte as frame text
    set_mode(1'b0);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_text("$#");
    send_rx(irsfp_pkg::CHAR_DOLLAR);
    send_rx(irsfp_pkg::CHAR_DOLLAR);
    send_rx(8'h00);
    send_text("345");
    send_rx(8'hFF);
    send_rx(irsfp_pkg::CHAR_HASH);
    drain_and_settle();

    // analog: wrap, signs, extra parts, empty first part, wrong kind byte
    set_mode(1'b1);
    send_text("$A,1:+65535 x:70000,k::3:9,:-7#");
    send_text("$B,1:5#");
    // mode flips while a frame is open
    send_text("$A,2:45");
    drain_and_settle();
    set_mode(1'b0);
    send_text("678#");

    rand_start = bytes_sent;
    for (int k = 0; bytes_sent - rand_start < RAND_BYTES; k++) begin
      steady = (k >= 5 && k < 10);
      if (k % 5 == 0) begin
        drain_and_settle();
        set_mode(1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 9) == 0) begin
        drain_and_settle();
      end
      pick = (k == 3) ? 99 : $urandom_range(0, 99);
      if (pick >= 97) begin
        // runs past the length limit without a '#'
        send_rx(irsfp_pkg::CHAR_DOLLAR);
        repeat (FRAME_LEN) send_rx(8'(irsfp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end else if (pick < (cur_mode ? 60 : 30)) begin
        send_rx(irsfp_pkg::CHAR_DOLLAR);
        send_rx(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                             : irsfp_pkg::CHAR_A);
        repeat ($urandom_range(0, 10)) begin
          repeat ($urandom_range(1, 2))
            send_rx($urandom_range(0, 1) ? irsfp_pkg::CHAR_COMMA : irsfp_pkg::CHAR_SPACE);
          repeat ($urandom_range(0, 2)) send_rx(8'($urandom_range(8'h61, 8'h7A)));
          if ($urandom_range(0, 9) != 0) send_rx(irsfp_pkg::CHAR_COLON);
          r = $urandom_range(0, 3);
          if (r == 1) send_rx(irsfp_pkg::CHAR_PLUS);
          else if (r == 2) send_rx(irsfp_pkg::CHAR_MINUS);
          repeat ($urandom_range(0, 5))
            send_rx(8'(irsfp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
          if ($urandom_range(0, 7) == 0) send_rx(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0) send_rx(irsfp_pkg::CHAR_SPACE);
        send_rx(irsfp_pkg::CHAR_HASH);
      end else if (pick < 85) begin
        send_rx(irsfp_pkg::CHAR_DOLLAR);
        repeat ($urandom_range(0, 45))
          send_rx(($urandom_range(0, 4) != 0)
                  ? 8'(irsfp_pkg::CHAR_ZERO + $urandom_range(0, 9))
                  : 8'($urandom_range(0, 255)));
        send_rx(irsfp_pkg::CHAR_HASH);
      end else begin
        // idle noise, may open a frame by chance
        repeat ($urandom_range(1, 6)) send_rx(8'($urandom_range(0, 255)));
      end
    end
    steady = 1'b0;
    drain_and_settle();

    $display("sent %0d rx bytes in digital and analog mode, %0d frames decoded, %0d over-long",
             bytes_sent, frames_closed, frames_dropped);
    $display("%0d channel readings compared in order", readings_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/irsfp_pkg.sv
src/irsfp_if.sv
src/irsfp_decoder.sv
src/irsfp_emitter.sv
src/ir_sensor_frame_parser.sv
bench/irsfp_reading_checker.sv
bench/ir_sensor_frame_parser_test.sv
